/* hw/rtl/tem_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tem_pkg
// Shared types and constants for the timer expiry manager.
// ----------------------------------------------------------------------------
package tem_pkg;
    localparam int TIMERS_DEF    = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam logic [31:0] GAP_RESET = 32'd10000;

    localparam logic [2:0] ACT_ADD     = 3'd0;
    localparam logic [2:0] ACT_CANCEL  = 3'd1;
    localparam logic [2:0] ACT_REFRESH = 3'd2;
    localparam logic [2:0] ACT_RESET   = 3'd3;
    localparam logic [2:0] ACT_TICK    = 3'd4;
    localparam logic [2:0] ACT_QUERY   = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FAIL    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EXPIRED = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_REARM,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic scan_clr;  // restart slot scan
        logic scan_step; // advance slot scan
        logic emit_sel;  // mark best as emitted and strobe event
        logic rearm;     // apply rearm / free pass
        logic single;    // strobe single-result answer
        logic done;      // strobe tick done
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic scan_end;
        logic found;     // scan found a candidate: a pending hit on tick, an active slot otherwise
        logic any_on;
    } t_sts;
endpackage
`default_nettype wire

/* hw/rtl/tem_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tem_datapath
// Slot table, sequential slot scan and result formatting.
// ----------------------------------------------------------------------------
module tem_datapath #(
    parameter int TIMERS    = 16,
    parameter int TIME_BITS = 48
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tem_pkg::t_cmd        i_cmd,
    output tem_pkg::t_sts             o_sts,
    input  wire logic                 i_cfg_valid,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic [2:0]           i_action,
    input  wire logic [3:0]           i_timer_id,
    input  wire logic [TIME_BITS-1:0] i_timeout,
    input  wire logic                 i_repeat_req,
    input  wire logic                 i_from_now,
    input  wire logic [TIME_BITS-1:0] i_time_now,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic [3:0]                o_slot_out,
    output logic [47:0]               o_remaining,
    output logic                      o_any_active,
    output logic                      o_last
);
    import tem_pkg::*;

    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CW = $clog2(TIMERS + 1);

    logic [TIMERS-1:0] r_active, r_repeat, r_hit, r_sent;
    logic [TIME_BITS-1:0] r_interval [TIMERS];
    logic [TIME_BITS-1:0] r_deadline [TIMERS];
    logic [TIME_BITS-1:0] r_prev;
    logic [31:0] r_gap;

    logic [2:0] r_act;
    logic [3:0] r_id;
    logic [TIME_BITS-1:0] r_tmo, r_now;
    logic r_rep, r_fnow, r_roll;

    logic [CW-1:0] r_idx;
    logic r_bfound;
    logic [IW-1:0] r_best;
    logic [TIME_BITS-1:0] r_bdl;

    logic r_valid, r_last;
    logic [2:0] r_status;
    logic [3:0] r_slot;
    logic [47:0] r_rem;

    logic [IW-1:0] cur;
    logic in_range, cur_act, cand, better, id_ok, id_act, any_on;
    logic [TIME_BITS-1:0] id_int;
    logic [47:0] query_rem;

    assign cur      = r_idx[IW-1:0];
    assign in_range = r_idx < CW'(TIMERS);
    assign cur_act  = in_range && r_active[cur];
    assign id_ok    = {28'd0, r_id} < 32'(TIMERS);
    assign id_act   = id_ok && r_active[r_id[IW-1:0]];
    assign id_int   = r_interval[r_id[IW-1:0]];
    assign any_on   = |r_active;

    // tick: pending hits not yet sent; other actions: active slots
    always_comb begin
        if (r_act == ACT_TICK)
            cand = in_range && r_hit[cur] && !r_sent[cur];
        else
            cand = cur_act;
        better = cand && (!r_bfound || r_deadline[cur] < r_bdl);
    end

    always_comb begin
        if (!r_bfound)
            query_rem = '1;
        else if (r_bdl <= r_now)
            query_rem = '0;
        else
            query_rem = 48'(r_bdl - r_now);
    end

    assign o_sts.is_tick  = (r_act == ACT_TICK);
    assign o_sts.scan_end = !in_range;
    assign o_sts.found    = r_bfound;
    assign o_sts.any_on   = any_on;

    logic free_found;
    logic [IW-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_repeat <= '0;
            r_prev   <= '0;
            r_gap    <= GAP_RESET;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_sel | i_cmd.done | i_cmd.single;
            if (i_cfg_valid)
                r_gap <= i_cfg_data;
            if (i_cmd.load) begin
                r_act  <= i_action;
                r_id   <= i_timer_id;
                r_tmo  <= i_timeout;
                r_rep  <= i_repeat_req;
                r_fnow <= i_from_now;
                r_now  <= i_time_now;
                r_sent <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_idx    <= '0;
                r_bfound <= 1'b0;
            end else if (i_cmd.scan_step && in_range) begin
                if (r_act == ACT_TICK && r_sent == '0 && !r_bfound && r_idx == '0) begin
                    // first pass of tick: rollover test and hit marking are done at load
                end
                if (better) begin
                    r_bfound <= 1'b1;
                    r_best   <= cur;
                    r_bdl    <= r_deadline[cur];
                end
                r_idx <= r_idx + CW'(1);
            end
            // hit vector once per tick, at load of the scan
            if (i_cmd.load && i_action == ACT_TICK) begin
                r_roll <= (i_time_now < r_prev) &&
                          ((r_prev - i_time_now) > TIME_BITS'(r_gap));
                for (int i = 0; i < TIMERS; i++)
                    r_hit[i] <= r_active[i] && (((i_time_now < r_prev) &&
                        ((r_prev - i_time_now) > TIME_BITS'(r_gap))) ||
                        r_deadline[i] <= i_time_now);
            end
            if (i_cmd.emit_sel) begin
                r_sent[r_best] <= 1'b1;
                r_status <= ST_EXPIRED;
                r_slot   <= 4'(r_best);
                r_rem    <= '0;
                r_last   <= 1'b0;
            end
            if (i_cmd.rearm) begin
                if (|r_active && !r_roll)
                    r_prev <= r_now;
                for (int i = 0; i < TIMERS; i++) begin
                    if (r_sent[i]) begin
                        if (r_repeat[i])
                            r_deadline[i] <= r_now + r_interval[i];
                        else
                            r_active[i] <= 1'b0;
                    end
                end
            end
            if (i_cmd.done) begin
                r_status <= ST_DONE;
                r_slot   <= '0;
                r_rem    <= '0;
                r_last   <= 1'b1;
            end
            if (i_cmd.single) begin
                r_slot  <= (r_act == ACT_ADD && free_found) ? 4'(free_idx) : 4'd0;
                r_rem   <= (r_act == ACT_QUERY) ? query_rem : 48'd0;
                r_last  <= 1'b1;
                unique case (r_act)
                    ACT_ADD: begin
                        if (free_found) begin
                            r_active[free_idx]   <= 1'b1;
                            r_repeat[free_idx]   <= r_rep;
                            r_interval[free_idx] <= r_tmo;
                            r_deadline[free_idx] <= r_now + r_tmo;
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    ACT_CANCEL: begin
                        if (id_act) begin
                            r_active[r_id[IW-1:0]] <= 1'b0;
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FAIL;
                        end
                    end
                    ACT_REFRESH: begin
                        if (id_act) begin
                            r_deadline[r_id[IW-1:0]] <= r_now + id_int;
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FAIL;
                        end
                    end
                    ACT_RESET: begin
                        if (id_ok && r_tmo == id_int && !r_fnow) begin
                            r_status <= ST_OK;
                        end else if (id_act) begin
                            r_interval[r_id[IW-1:0]] <= r_tmo;
                            r_deadline[r_id[IW-1:0]] <= r_now + r_tmo;
                            r_status <= ST_OK;
                        end else begin
                            r_status <= ST_FAIL;
                        end
                    end
                    ACT_QUERY: r_status <= ST_OK;
                    default: r_status <= ST_FAIL;
                endcase
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_slot_out   = r_slot;
    assign o_remaining  = r_rem;
    // events go out before the rearm pass: report the table as it will be after it
    assign o_any_active = (r_status == ST_EXPIRED) ? |(r_active & ~(r_hit & ~r_repeat))
                                                   : any_on;
    assign o_last       = r_last;
endmodule
`default_nettype wire

/* hw/rtl/tem_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tem_ctrl
// Sequencer for item intake, slot scans, event emission and rearm.
// ----------------------------------------------------------------------------
module tem_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire tem_pkg::t_sts i_sts,
    output tem_pkg::t_cmd      o_cmd
);
    import tem_pkg::*;

    t_state r_state, n_state;
    logic r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                n_state = S_SCAN;
                n_first = 1'b1;
            end
            S_SCAN: if (r_first) begin
                // settle state so the item registers are loaded
                n_first = 1'b0;
                if (i_sts.is_tick && !i_sts.any_on)
                    n_state = S_DONE;
            end else if (i_sts.scan_end) begin
                if (!i_sts.is_tick)       n_state = S_IDLE;
                else if (i_sts.found)     n_state = S_EMIT;
                else                      n_state = S_REARM;
            end
            S_EMIT:  n_state = S_SCAN;
            S_REARM: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load     = i_start;
                o_cmd.scan_clr = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan_step = !r_first;
                if (!r_first && i_sts.scan_end && !i_sts.is_tick)
                    o_cmd.single = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit_sel = 1'b1;
                o_cmd.scan_clr = 1'b1;
            end
            S_REARM: o_cmd.rearm = 1'b1;
            S_DONE:  o_cmd.done  = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

/* hw/rtl/timer_expiry_manager.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// timer_expiry_manager
// Timer slot table with add, cancel, refresh, reset, query and tick.
// ----------------------------------------------------------------------------
// Non-tick items: one slot scan, then the result strobe; busy drops with the strobe,
// so no new item is taken before the last one's result is out.
// Tick: one scan per expired slot plus a final scan, then the done strobe; with no
// active timer the scans are skipped. Busy is high until the strobe.
// Results are single-cycle strobes; the receiver cannot stall.
// Synchronous reset clears all slots and previous time; gap returns to 10000.
module timer_expiry_manager
    import tem_pkg::*;
#(
    parameter int TIMERS    = TIMERS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic [2:0]           i_action,
    input  wire logic [3:0]           i_timer_id,
    input  wire logic [TIME_BITS-1:0] i_timeout,
    input  wire logic                 i_repeat_req,
    input  wire logic                 i_from_now,
    input  wire logic [TIME_BITS-1:0] i_time_now,
    output logic                      o_valid,
    output logic [2:0]                o_status,
    output logic [3:0]                o_slot_out,
    output logic [47:0]               o_remaining,
    output logic                      o_any_active,
    output logic                      o_last
);
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tem_datapath #(.TIMERS(TIMERS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_timer_id   (i_timer_id),
        .i_timeout    (i_timeout),
        .i_repeat_req (i_repeat_req),
        .i_from_now   (i_from_now),
        .i_time_now   (i_time_now),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_remaining  (o_remaining),
        .o_any_active (o_any_active),
        .o_last       (o_last)
    );
endmodule
`default_nettype wire

/* verif/tb_timer_expiry_manager.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_expiry_manager
// Self-checking bench for the timer slot table: directed actions first,
// then random add/cancel/refresh/reset/tick/query traffic under several
// rollover gap settings, every result checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_timer_expiry_manager;
    import tem_pkg::*;

    localparam int NSLOT = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [47:0] remaining;
        logic        any_active;
        logic        last;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic [2:0]  i_action = '0;
    logic [3:0]  i_timer_id = '0;
    logic [47:0] i_timeout = '0;
    logic        i_repeat_req = 1'b0;
    logic        i_from_now = 1'b0;
    logic [47:0] i_time_now = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_slot_out;
    logic [47:0] o_remaining;
    logic        o_any_active;
    logic        o_last;

    timer_expiry_manager u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_timer_id   (i_timer_id),
        .i_timeout    (i_timeout),
        .i_repeat_req (i_repeat_req),
        .i_from_now   (i_from_now),
        .i_time_now   (i_time_now),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_slot_out   (o_slot_out),
        .o_remaining  (o_remaining),
        .o_any_active (o_any_active),
        .o_last       (o_last)
    );

    // timer table mirror
    logic        tbl_active   [NSLOT];
    logic        tbl_repeat   [NSLOT];
    logic        tbl_written  [NSLOT];
    logic [47:0] tbl_interval [NSLOT];
    logic [47:0] tbl_deadline [NSLOT];
    logic [47:0] last_tick_time;
    logic [31:0] gap_reg;

    t_answer pending_answers[$];
    int      err_count = 0;
    int      cycle_count = 0;
    int      idle_pct = 0;
    logic [47:0] clock_time = '0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", o_status, want.status));
                if (o_slot_out !== want.slot)
                    report_mismatch($sformatf("slot %0d want %0d", o_slot_out, want.slot));
                if (o_remaining !== want.remaining)
                    report_mismatch($sformatf("remaining %h want %h", o_remaining,
                                              want.remaining));
                if (o_any_active !== want.any_active)
                    report_mismatch($sformatf("any_active %0b want %0b", o_any_active,
                                              want.any_active));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b want %0b", o_last, want.last));
            end
        end
    end

    function automatic logic table_busy();
        for (int i = 0; i < NSLOT; i++)
            if (tbl_active[i]) return 1'b1;
        return 1'b0;
    endfunction

    // Work out the answers of one transfer and update the mirror.
    task automatic predict_answers(input logic [2:0] act, input logic [3:0] id,
                                   input logic [47:0] tmo, input logic rep,
                                   input logic fnow, input logic [47:0] now);
        t_answer ans[$];
        t_answer one;
        logic [1:0] hit [NSLOT];
        int best;
        logic roll;
        one = '0;
        case (act)
            ACT_ADD: begin
                best = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (!tbl_active[i] && best < 0) best = i;
                if (best < 0) begin
                    one.status = ST_FULL;
                end else begin
                    tbl_active[best]   = 1'b1;
                    tbl_repeat[best]   = rep;
                    tbl_written[best]  = 1'b1;
                    tbl_interval[best] = tmo;
                    tbl_deadline[best] = now + tmo;
                    one.status = ST_OK;
                    one.slot = best[3:0];
                end
                ans = {ans, one};
            end
            ACT_CANCEL: begin
                one.status = tbl_active[id] ? ST_OK : ST_FAIL;
                tbl_active[id] = 1'b0;
                ans = {ans, one};
            end
            ACT_REFRESH: begin
                one.status = tbl_active[id] ? ST_OK : ST_FAIL;
                if (tbl_active[id]) tbl_deadline[id] = now + tbl_interval[id];
                ans = {ans, one};
            end
            ACT_RESET: begin
                if (tmo == tbl_interval[id] && !fnow) begin
                    one.status = ST_OK;
                end else if (tbl_active[id]) begin
                    tbl_interval[id] = tmo;
                    tbl_deadline[id] = now + tmo;
                    one.status = ST_OK;
                end else begin
                    one.status = ST_FAIL;
                end
                ans = {ans, one};
            end
            ACT_TICK: begin
                if (table_busy()) begin
                    roll = (now < last_tick_time) && ((last_tick_time - now) > {16'd0, gap_reg});
                    if (!roll) last_tick_time = now;
                    for (int i = 0; i < NSLOT; i++)
                        hit[i] = (tbl_active[i] && (roll || tbl_deadline[i] <= now)) ? 2'd1 : 2'd0;
                    forever begin
                        best = -1;
                        for (int i = 0; i < NSLOT; i++)
                            if (hit[i] == 2'd1 &&
                                (best < 0 || tbl_deadline[i] < tbl_deadline[best]))
                                best = i;
                        if (best < 0) break;
                        hit[best] = 2'd2;
                        one = '0;
                        one.status = ST_EXPIRED;
                        one.slot = best[3:0];
                        ans = {ans, one};
                    end
                    for (int i = 0; i < NSLOT; i++)
                        if (hit[i] == 2'd2) begin
                            if (tbl_repeat[i]) tbl_deadline[i] = now + tbl_interval[i];
                            else tbl_active[i] = 1'b0;
                        end
                end
                one = '0;
                one.status = ST_DONE;
                ans = {ans, one};
            end
            ACT_QUERY: begin
                best = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_active[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best]))
                        best = i;
                one.status = ST_OK;
                if (best < 0) one.remaining = ALL_ONES;
                else if (tbl_deadline[best] <= now) one.remaining = '0;
                else one.remaining = tbl_deadline[best] - now;
                ans = {ans, one};
            end
            default: begin
                one.status = ST_FAIL;
                ans = {ans, one};
            end
        endcase
        foreach (ans[k]) begin
            ans[k].any_active = table_busy();
            ans[k].last = (k == ans.size() - 1);
            pending_answers = {pending_answers, ans[k]};
        end
    endtask

    // Send one item; start stays high when no idle cycles follow.
    task automatic send_item(input logic [2:0] act, input logic [3:0] id,
                             input logic [47:0] tmo, input logic rep,
                             input logic fnow, input logic [47:0] now);
        int gap;
        i_action     <= act;
        i_timer_id   <= id;
        i_timeout    <= tmo;
        i_repeat_req <= rep;
        i_from_now   <= fnow;
        i_time_now   <= now;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_answers(act, id, tmo, rep, fnow, now);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start, drain all answers, then let the block settle.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        gap_reg = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        clock_time = 48'd1000;
        send_item(ACT_QUERY, 4'd0, '0, 1'b0, 1'b0, clock_time);       // empty table
        send_item(ACT_TICK, 4'd0, '0, 1'b0, 1'b0, clock_time);        // nothing active
        send_item(ACT_ADD, 4'd0, 48'd5, 1'b0, 1'b0, clock_time);
        send_item(ACT_ADD, 4'd0, 48'd5, 1'b1, 1'b0, clock_time);      // equal deadline
        send_item(ACT_ADD, 4'd0, ALL_ONES, 1'b1, 1'b1, clock_time);   // wraps
        send_item(ACT_ADD, 4'd0, 48'd0, 1'b0, 1'b0, clock_time);      // already due
        send_item(ACT_QUERY, 4'd0, '0, 1'b0, 1'b0, clock_time);
        send_item(ACT_RESET, 4'd0, 48'd5, 1'b0, 1'b0, clock_time);    // unchanged, no-op
        send_item(ACT_RESET, 4'd1, 48'd5, 1'b0, 1'b1, clock_time + 1); // forced restart
        send_item(ACT_REFRESH, 4'd0, '0, 1'b0, 1'b0, clock_time + 2);
        send_item(ACT_QUERY, 4'd0, '0, 1'b0, 1'b0, clock_time + 10);
        send_item(ACT_TICK, 4'd0, '0, 1'b0, 1'b0, clock_time + 10);
        send_item(ACT_CANCEL, 4'd0, '0, 1'b0, 1'b0, clock_time);      // freed by tick
        send_item(ACT_CANCEL, 4'd2, '0, 1'b0, 1'b0, clock_time);
        send_item(ACT_REFRESH, 4'd9, '0, 1'b0, 1'b0, clock_time);     // never added
        send_item(ACT_RESET, 4'd9, 48'd7, 1'b0, 1'b1, clock_time);    // inactive slot
        send_item(3'd6, 4'hF, ALL_ONES, 1'b1, 1'b1, ALL_ONES);
        send_item(3'd7, 4'd0, '0, 1'b0, 1'b0, '0);
        // backward jump within the gap: no rollover, nothing expires
        send_item(ACT_TICK, 4'd0, '0, 1'b0, 1'b0, 48'd0);
        send_item(ACT_QUERY, 4'd0, '0, 1'b0, 1'b0, 48'd0);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [2:0]  act;
        logic [3:0]  id;
        logic [47:0] tmo;
        logic        fnow;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            // time mostly moves forward; sometimes back, sometimes anywhere
            if (pick < 4) clock_time = 48'({$urandom, $urandom});
            else if (pick < 10) clock_time = clock_time - 48'($urandom_range(20000));
            else clock_time = clock_time + 48'($urandom_range(40));
            pick = $urandom_range(99);
            if (pick < 30) act = ACT_ADD;
            else if (pick < 55) act = ACT_TICK;
            else if (pick < 65) act = ACT_CANCEL;
            else if (pick < 75) act = ACT_REFRESH;
            else if (pick < 85) act = ACT_RESET;
            else if (pick < 97) act = ACT_QUERY;
            else act = 3'($urandom_range(7, 6));
            id = 4'($urandom);
            tmo = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                           : 48'($urandom_range(60));
            fnow = 1'($urandom);
            // avoid comparing against an interval that was never written
            if (act == ACT_RESET && !tbl_written[id]) fnow = 1'b1;
            send_item(act, id, tmo, 1'($urandom), fnow, clock_time);
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_active[i] = 1'b0;
            tbl_repeat[i] = 1'b0;
            tbl_written[i] = 1'b0;
            tbl_interval[i] = '0;
            tbl_deadline[i] = '0;
        end
        last_tick_time = '0;
        gap_reg = GAP_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 9;
        test_directed();
        test_random(60);
        write_gap(32'd0);
        test_random(60);
        idle_pct = 85;
        write_gap(32'hFFFF_FFFF);
        test_random(70);
        write_gap($urandom_range(30000));
        test_random(60);
        idle_pct = 0;
        write_gap(GAP_RESET);
        test_random(60);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
